// ----- sv/dsm_pkg.sv -----
package dsm_pkg;

  // register indexes on the config port
  localparam logic [2:0] REG_POS_X     = 3'd0;
  localparam logic [2:0] REG_POS_Y     = 3'd1;
  localparam logic [2:0] REG_TOP_SPEED = 3'd2;
  localparam logic [2:0] REG_GAIN_P    = 3'd3;
  localparam logic [2:0] REG_GAIN_I    = 3'd4;
  localparam logic [2:0] REG_GAIN_D    = 3'd5;

  localparam int DIV_W = 64;   // divider operand width
  localparam int QB_W  = 6;    // quotient bit counter width

  localparam logic [15:0] TWO_PI_Q12 = 16'd25736;
  localparam logic [63:0] ONE_Q20    = 64'd1 << 20;
  localparam logic [15:0] QUARTER    = 16'd16384;
  localparam logic [15:0] HALF       = 16'd32768;

  // rounded arctangent of 2^-i as a 16-bit binary angle
  function automatic logic [15:0] atan_ba(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'd8192;
      5'd1:    r = 16'd4836;
      5'd2:    r = 16'd2555;
      5'd3:    r = 16'd1297;
      5'd4:    r = 16'd651;
      5'd5:    r = 16'd326;
      5'd6:    r = 16'd163;
      5'd7:    r = 16'd81;
      5'd8:    r = 16'd41;
      5'd9:    r = 16'd20;
      5'd10:   r = 16'd10;
      5'd11:   r = 16'd5;
      5'd12:   r = 16'd3;
      5'd13:   r = 16'd1;
      5'd14:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/dsm_cordic.sv -----
module dsm_cordic import dsm_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  output logic               busy,
  output logic [15:0]        angle
);

  localparam int CW = $clog2(STEPS + 1);

  logic signed [34:0] x, y;
  logic [CW-1:0]      cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      cnt <= '0;
      if (x_in == 32'sd0 && y_in == 32'sd0) begin
        angle <= 16'd0;
        busy  <= 1'b0;
      end else if (x_in < 0) begin
        x     <= -35'(x_in);
        y     <= -35'(y_in);
        angle <= HALF;
        busy  <= 1'b1;
      end else begin
        x     <= 35'(x_in);
        y     <= 35'(y_in);
        angle <= 16'd0;
        busy  <= 1'b1;
      end
    end else if (busy) begin
      if (y >= 0) begin
        x     <= x + (y >>> cnt);
        y     <= y - (x >>> cnt);
        angle <= angle + atan_ba(5'(cnt));
      end else begin
        x     <= x - (y >>> cnt);
        y     <= y + (x >>> cnt);
        angle <= angle - atan_ba(5'(cnt));
      end
      cnt <= cnt + 1'b1;
      if (cnt == CW'(STEPS - 1)) busy <= 1'b0;
    end
  end

endmodule

// ----- sv/dsm_sqrt.sv -----
module dsm_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] rem, res, one;
  logic [64:0] trial;

  assign trial = {1'b0, rem} - ({1'b0, res} + {1'b0, one});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem  <= radicand;
      res  <= '0;
      one  <= 64'd1 << 62;
      busy <= 1'b1;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
      if (one[0]) busy <= 1'b0;
    end
  end

  assign root = res[31:0];

endmodule

// ----- sv/dsm_div.sv -----
module dsm_div import dsm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num_hi,   // starting remainder, below den
  input  logic [DIV_W-1:0] num_lo,   // bits brought down, msb first
  input  logic [QB_W-1:0]  qbits,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic [DIV_W-1:0] quot
);

  logic [DIV_W-1:0] rem, lo, dv;
  logic [QB_W-1:0]  cnt, idx;
  logic [DIV_W:0]   shifted, diff;

  assign idx     = cnt - 1'b1;
  assign shifted = {rem, lo[idx]};
  assign diff    = shifted - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= num_hi;
      lo   <= num_lo;
      dv   <= den;
      cnt  <= qbits;
      quot <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (!diff[DIV_W]) begin
        rem  <= diff[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
      cnt <= idx;
      if (cnt == QB_W'(1)) busy <= 1'b0;
    end
  end

endmodule

// ----- sv/diff_swerve_module_drive_core.sv -----
// channel   | dir | signals                          | contents
// s_axis    | in  | s_tvalid s_tready s_tdata[63:0]  | vel_x, vel_y, turn_rate, steer_angle
// m_axis    | out | m_tvalid m_tready m_tdata[15:0]  | left_power, right_power
// cfg       | in  | cfg_valid cfg_ready cfg_index cfg_data | register writes, always ready
//
// time per word, from accept to next accept with CORDIC_STEPS up to 24, goes mostly to the 32-step
// square root and the 40-step drive division, then to two 7-step power divisions;
// a word whose three commands are zero goes from idle straight to the output state
// s_tready is high only in idle; a finished word waits in the output register
// while the next input word is taken
// rst is synchronous and clears control state, pid state and config registers
module diff_swerve_module_drive_core import dsm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // vel_x[15:0] vel_y[31:16] turn_rate[47:32] steer_angle[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // left_power[7:0] right_power[15:8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_TX, S_TY, S_SQX, S_SQY, S_ROOT, S_RWAIT, S_DRV, S_DRVW,
    S_ERAD, S_GP, S_GD, S_GI, S_AB, S_PA, S_PAW, S_PB, S_PBW, S_FIN
  } state_t;

  state_t state;

  // config registers
  logic signed [15:0] module_pos_x, module_pos_y, gain_p, gain_i, gain_d;
  logic [14:0]        top_speed;

  // pid state
  logic signed [15:0] last_error;
  logic signed [31:0] error_sum;

  // per-word working registers
  logic signed [15:0] vel_x, vel_y, turn_rate;
  logic [15:0]        steer_angle;
  logic signed [31:0] tx, ty;
  logic [63:0]        sumsq;
  logic signed [15:0] err;
  logic               flip;
  logic signed [40:0] drive;
  logic signed [16:0] deriv;
  logic signed [48:0] acc;
  logic [48:0]        mag_a, mag_b;
  logic [63:0]        den;
  logic               neg_a, neg_b;
  logic signed [7:0]  left_power, right_power;

  // shared multiplier, registered product
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic [31:0] sq_root;
  logic        sq_busy, co_busy, dv_busy;
  logic [15:0] co_angle;
  logic        dv_start;
  logic [63:0] dv_hi, dv_lo, dv_quot;
  logic [5:0]  dv_qb;
  logic [63:0] dv_den_c;

  // heading error and its half-turn fold
  logic [15:0]        d_raw, d_fold;
  logic signed [15:0] e_raw;
  logic               past_quarter;

  // e_rad truncated toward zero, saturated integral, a and b
  logic signed [31:0] ep;
  logic [31:0]        ep_mag;
  logic signed [15:0] erad_c;
  logic signed [32:0] es_wide;
  logic signed [31:0] esum_c;
  logic signed [48:0] turn_c, a_c, b_c;
  logic [48:0]        ma_c, mb_c, m_c;
  logic [63:0]        pa_prod, pb_prod;

  always_comb begin
    d_raw        = co_angle - steer_angle;
    e_raw        = signed'(d_raw);
    past_quarter = (e_raw > signed'(QUARTER)) || (e_raw < -signed'({1'b0, QUARTER[14:0]}));
    d_fold       = past_quarter ? d_raw + HALF : d_raw;

    ep      = prod[31:0];
    ep_mag  = ep[31] ? 32'(-ep) : 32'(ep);
    erad_c  = ep[31] ? -16'(ep_mag >> 16) : 16'(ep_mag >> 16);
    es_wide = 33'(error_sum) + 33'(erad_c);
    if (es_wide > 33'sh0_7FFF_FFFF)
      esum_c = 32'sh7FFF_FFFF;
    else if (es_wide < -33'sh0_8000_0000)
      esum_c = 32'sh8000_0000;
    else
      esum_c = es_wide[31:0];

    turn_c  = acc + prod[48:0];
    a_c     = 49'(drive) + turn_c;
    b_c     = turn_c - 49'(drive);
    ma_c    = a_c[48] ? 49'(-a_c) : 49'(a_c);
    mb_c    = b_c[48] ? 49'(-b_c) : 49'(b_c);
    m_c     = (ma_c > mb_c) ? ma_c : mb_c;
    pa_prod = ({15'd0, mag_a} << 7) - {15'd0, mag_a};
    pb_prod = ({15'd0, mag_b} << 7) - {15'd0, mag_b};
  end

  // multiplier operand select
  always_comb begin
    case (state)
      S_TX:    begin mul_a = 32'(turn_rate); mul_b = 32'(module_pos_y); end
      S_TY:    begin mul_a = 32'(turn_rate); mul_b = 32'(module_pos_x); end
      S_SQX:   begin mul_a = tx;             mul_b = tx;                end
      S_SQY:   begin mul_a = ty;             mul_b = ty;                end
      S_ERAD:  begin mul_a = 32'(err);       mul_b = 32'(TWO_PI_Q12);   end
      S_GP:    begin mul_a = 32'(erad_c);    mul_b = 32'(gain_p);       end
      S_GD:    begin mul_a = 32'(deriv);     mul_b = 32'(gain_d);       end
      S_GI:    begin mul_a = error_sum;      mul_b = 32'(gain_i);       end
      default: begin mul_a = '0;             mul_b = '0;                end
    endcase
  end

  // divider operand select
  always_comb begin
    dv_start = 1'b0;
    dv_hi    = '0;
    dv_lo    = '0;
    dv_qb    = '0;
    dv_den_c = den;
    case (state)
      S_DRV: begin
        dv_start = 1'b1;
        dv_lo    = {24'd0, sq_root, 8'd0};
        dv_qb    = 6'd40;
        dv_den_c = (top_speed == 15'd0) ? 64'd1 : {49'd0, top_speed};
      end
      S_PA: begin
        dv_start = 1'b1;
        dv_hi    = pa_prod >> 7;
        dv_lo    = {57'd0, pa_prod[6:0]};
        dv_qb    = 6'd7;
      end
      S_PB: begin
        dv_start = 1'b1;
        dv_hi    = pb_prod >> 7;
        dv_lo    = {57'd0, pb_prod[6:0]};
        dv_qb    = 6'd7;
      end
      default: ;
    endcase
  end

  // radicand is tx^2 held plus ty^2 straight from the multiplier
  dsm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(state == S_ROOT), .radicand(sumsq + prod),
    .busy(sq_busy), .root(sq_root)
  );

  dsm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(state == S_ROOT), .x_in(tx), .y_in(ty),
    .busy(co_busy), .angle(co_angle)
  );

  dsm_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num_hi(dv_hi), .num_lo(dv_lo),
    .qbits(dv_qb), .den(dv_den_c), .busy(dv_busy), .quot(dv_quot)
  );

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_pos_x <= '0;
      module_pos_y <= '0;
      top_speed    <= 15'd4096;
      gain_p       <= 16'sd256;
      gain_i       <= '0;
      gain_d       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POS_X:     module_pos_x <= cfg_data;
        REG_POS_Y:     module_pos_y <= cfg_data;
        REG_TOP_SPEED: top_speed    <= cfg_data[14:0];
        REG_GAIN_P:    gain_p       <= cfg_data;
        REG_GAIN_I:    gain_i       <= cfg_data;
        REG_GAIN_D:    gain_d       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      last_error <= '0;
      error_sum  <= '0;
    end else begin
      // a new word in S_FIN overrides the clear
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid) begin
          vel_x       <= s_tdata[15:0];
          vel_y       <= s_tdata[31:16];
          turn_rate   <= s_tdata[47:32];
          steer_angle <= s_tdata[63:48];
          if (s_tdata[47:0] == 48'd0) begin
            // all commands zero: no motion, pid untouched
            left_power  <= '0;
            right_power <= '0;
            state       <= S_FIN;
          end else begin
            state <= S_TX;
          end
        end
        S_TX:  state <= S_TY;
        S_TY:  begin tx <= (32'(vel_x) <<< 12) - prod[31:0]; state <= S_SQX; end
        S_SQX: begin ty <= (32'(vel_y) <<< 12) + prod[31:0]; state <= S_SQY; end
        S_SQY: begin sumsq <= prod; state <= S_ROOT; end
        S_ROOT: state <= S_RWAIT;
        S_RWAIT: if (!sq_busy && !co_busy) begin
          err   <= signed'(d_fold);
          flip  <= past_quarter;
          state <= S_DRV;
        end
        S_DRV: state <= S_DRVW;
        S_DRVW: if (!dv_busy) begin
          drive <= flip ? -41'(dv_quot[40:0]) : 41'(dv_quot[40:0]);
          state <= S_ERAD;
        end
        S_ERAD: state <= S_GP;
        S_GP: begin
          deriv      <= 17'(erad_c) - 17'(last_error);
          last_error <= erad_c;
          error_sum  <= esum_c;
          state      <= S_GD;
        end
        S_GD: begin acc <= prod[48:0]; state <= S_GI; end
        S_GI: begin acc <= acc + prod[48:0]; state <= S_AB; end
        S_AB: begin
          mag_a <= ma_c;
          mag_b <= mb_c;
          neg_a <= a_c[48];
          neg_b <= b_c[48];
          den   <= (64'(m_c) > ONE_Q20) ? 64'(m_c) : ONE_Q20;
          state <= S_PA;
        end
        S_PA: state <= S_PAW;
        S_PAW: if (!dv_busy) begin
          left_power <= neg_a ? -8'(dv_quot[6:0]) : 8'(dv_quot[6:0]);
          state      <= S_PB;
        end
        S_PB: state <= S_PBW;
        S_PBW: if (!dv_busy) begin
          right_power <= neg_b ? -8'(dv_quot[6:0]) : 8'(dv_quot[6:0]);
          state       <= S_FIN;
        end
        S_FIN: if (!m_tvalid || m_tready) begin
          m_tdata  <= {right_power, left_power};
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice in a row");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
    else $error("power out of range");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    dv_start |-> !dv_busy)
    else $error("divider restarted while busy");

endmodule
